@@ hdl/luma_contrast_stretch_curve_assert.svh @@
// Assertion macros for the luma contrast stretch block.
// Used by luma_contrast_stretch_curve.sv; no other dependencies.
`ifndef LUMA_CONTRAST_STRETCH_CURVE_ASSERT_SVH
`define LUMA_CONTRAST_STRETCH_CURVE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define LCS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define LCS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/lcs_pkg.sv @@
// Shared types and constants for the luma contrast stretch block.
// No dependencies; used by every module in hdl/.
`timescale 1ns / 1ps

package lcs_pkg;

   localparam int BYTE_W    = 8;
   localparam int GAIN_W    = 15;
   localparam int FMT_W     = 2;
   localparam int IDX_W     = 2;
   localparam int MUL_SHIFT = 7;
   localparam int SQ_SHIFT  = 8;

   localparam logic [GAIN_W-1:0] GAIN_MAX   = 15'd32767;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd128;
   localparam logic [BYTE_W-1:0] BYTE_MAX   = 8'd255;

   // pixel formats
   localparam logic [FMT_W-1:0] FMT_PLANAR = 2'd0;
   localparam logic [FMT_W-1:0] FMT_YUYV   = 2'd1;
   localparam logic [FMT_W-1:0] FMT_UYVY   = 2'd2;

   // register indexes
   localparam logic [IDX_W-1:0] IDX_LOW_LEVEL    = 2'd0;
   localparam logic [IDX_W-1:0] IDX_HIGH_LEVEL   = 2'd1;
   localparam logic [IDX_W-1:0] IDX_PIXEL_FORMAT = 2'd2;

   typedef struct packed {
      logic              adv;
      logic [BYTE_W-1:0] low_level;
      logic [GAIN_W-1:0] gain;
   } lcs_lane_ctl_type;

   typedef struct packed {
      logic              busy;
      logic [GAIN_W-1:0] gain;
   } lcs_gain_status_type;

endpackage

@@ hdl/lcs_luma_lane.sv @@
// Four-stage luma datapath for one byte: offset, gain, clamp, soft curve.
// Depends on lcs_pkg.
`timescale 1ns / 1ps

module lcs_luma_lane (
   input  logic                       clock,
   input  lcs_pkg::lcs_lane_ctl_type  ctl,
   input  logic [lcs_pkg::BYTE_W-1:0] in_byte,
   input  logic                       bypass,
   output logic [lcs_pkg::BYTE_W-1:0] out_byte
);
   import lcs_pkg::*;

   localparam int PROD_W   = BYTE_W + GAIN_W;
   localparam int SCALED_W = PROD_W - MUL_SHIFT;
   localparam int SQ_W     = 2 * BYTE_W;

   // stage 1
   logic [BYTE_W-1:0] t1_ff, t1_in, raw1_ff;
   logic              byp1_ff;
   // stage 2
   logic [PROD_W-1:0] prod2_ff, prod2_in;
   logic [BYTE_W-1:0] raw2_ff;
   logic              byp2_ff;
   // stage 3
   logic [SCALED_W-1:0] scaled3;
   logic [BYTE_W-1:0]   t3_ff, t3_in, inv3, raw3_ff;
   logic [SQ_W-1:0]     sq3_ff, sq3_in;
   logic                byp3_ff;
   // stage 4
   logic [BYTE_W:0]     soft4;
   logic [BYTE_W-1:0]   out4_ff, out4_in;

   assign t1_in    = (in_byte >= ctl.low_level) ? (in_byte - ctl.low_level) : '0;
   assign prod2_in = PROD_W'(t1_ff) * PROD_W'(ctl.gain);

   assign scaled3 = SCALED_W'(prod2_ff >> MUL_SHIFT);
   assign t3_in   = (|scaled3[SCALED_W-1:BYTE_W]) ? BYTE_MAX : scaled3[BYTE_W-1:0];
   assign inv3    = BYTE_MAX - t3_in;
   assign sq3_in  = SQ_W'(inv3) * SQ_W'(inv3);

   // (t + 255 - (inv^2 >> 8)) >> 1; the difference never goes negative
   assign soft4   = {1'b0, BYTE_MAX - BYTE_W'(sq3_ff >> SQ_SHIFT)} + {1'b0, t3_ff};
   assign out4_in = byp3_ff ? raw3_ff : soft4[BYTE_W:1];

   always_ff @(posedge clock) begin
      if (ctl.adv) begin
         t1_ff    <= t1_in;
         raw1_ff  <= in_byte;
         byp1_ff  <= bypass;
         prod2_ff <= prod2_in;
         raw2_ff  <= raw1_ff;
         byp2_ff  <= byp1_ff;
         t3_ff    <= t3_in;
         sq3_ff   <= sq3_in;
         raw3_ff  <= raw2_ff;
         byp3_ff  <= byp2_ff;
         out4_ff  <= out4_in;
      end
   end

   assign out_byte = out4_ff;

endmodule

@@ hdl/lcs_gain_div.sv @@
// Restoring divider for the stretch gain: 32767 / divisor, one bit a cycle.
// Depends on lcs_pkg.
`timescale 1ns / 1ps

module lcs_gain_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [lcs_pkg::BYTE_W:0]      divisor,   // signed, 9 bits
   output lcs_pkg::lcs_gain_status_type  status
);
   import lcs_pkg::*;

   localparam int CNT_W = $clog2(GAIN_W);
   localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(GAIN_W - 1);

   logic              busy_ff, busy_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [BYTE_W-1:0] dvs_ff, dvs_in;
   logic [BYTE_W-1:0] rem_ff, rem_in;
   logic [GAIN_W-1:0] quo_ff, quo_in;
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [BYTE_W:0]   rem_sh, rem_sub;
   logic              fits;
   logic              saturate;

   assign saturate = divisor[BYTE_W] || (divisor == '0);
   assign rem_sh   = {rem_ff, GAIN_MAX[LAST_STEP - cnt_ff]};
   assign fits     = (rem_sh >= {1'b0, dvs_ff});
   assign rem_sub  = rem_sh - {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      gain_in = gain_ff;
      if (start) begin
         if (saturate) begin
            gain_in = GAIN_MAX;
            busy_in = 1'b0;
         end else begin
            busy_in = 1'b1;
            cnt_in  = '0;
            dvs_in  = divisor[BYTE_W-1:0];
            rem_in  = '0;
            quo_in  = '0;
         end
      end else if (busy_ff) begin
         rem_in = fits ? rem_sub[BYTE_W-1:0] : rem_sh[BYTE_W-1:0];
         quo_in = {quo_ff[GAIN_W-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LAST_STEP) begin
            busy_in = 1'b0;
            gain_in = quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
         gain_ff <= GAIN_RESET;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
         gain_ff <= gain_in;
      end
   end

   always_ff @(posedge clock) begin
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.gain = gain_ff;

endmodule

@@ hdl/luma_contrast_stretch_curve.sv @@
// Luma contrast stretch with soft curve (top level).
// Takes one byte pair per item on the req_ channel, returns it on rsp_.
// Channels: req_/rsp_ use valid and stall; an item moves at a clock edge
//   with valid high and stall low. req_stall comes straight from flops.
// Config: csr_write_enable/csr_index/csr_write_data; index 0 low level,
//   1 high level, 2 pixel format. Other indexes are ignored.
// Path: an accepted item passes the offset, multiply, clamp and square, and
//   curve registers before rsp_valid rises; a wait in the skid register or
//   a receiver stall delays it further.
// Throughput: one item per clock while req_stall is low; the stage chain
//   advances whenever the output register is empty or taken.
// Gain: a register write starts a bit-serial divide of 32767, one
//   quotient bit per cycle; req_stall stays high after the write through
//   the divider start and its 15 steps. A zero or negative divisor saturates
//   the gain at once.
// Reset: clears all valid bits and loads low 0, high 255, planar format
//   and a gain of 128; the block is ready as soon as reset is released.
// Receiver stall: the whole chain freezes, the output holds, and one
//   more input item is caught in the skid register before req_stall rises.
`timescale 1ns / 1ps

module luma_contrast_stretch_curve (
   input  logic                       clock,
   input  logic                       reset,
   // configuration
   input  logic                       csr_write_enable,
   input  logic [lcs_pkg::IDX_W-1:0]  csr_index,
   input  logic [lcs_pkg::BYTE_W-1:0] csr_write_data,
   // input items
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [lcs_pkg::BYTE_W-1:0] req_in_first,
   input  logic [lcs_pkg::BYTE_W-1:0] req_in_second,
   input  logic                       req_line_end,
   // result items
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [lcs_pkg::BYTE_W-1:0] rsp_out_first,
   output logic [lcs_pkg::BYTE_W-1:0] rsp_out_second,
   output logic                       rsp_line_end_out
);
   import lcs_pkg::*;

   `include "luma_contrast_stretch_curve_assert.svh"

   // ---- configuration registers ----
   logic [BYTE_W-1:0] low_ff, low_in;
   logic [BYTE_W-1:0] high_ff, high_in;
   logic [FMT_W-1:0]  fmt_ff, fmt_in;
   logic              cfg_hit;
   logic              div_start_ff;
   logic [BYTE_W:0]   divisor;
   lcs_gain_status_type gain_status;

   assign cfg_hit = csr_write_enable &&
                    (csr_index == IDX_LOW_LEVEL || csr_index == IDX_HIGH_LEVEL ||
                     csr_index == IDX_PIXEL_FORMAT);

   always_comb begin
      low_in  = low_ff;
      high_in = high_ff;
      fmt_in  = fmt_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            IDX_LOW_LEVEL:    low_in  = csr_write_data;
            IDX_HIGH_LEVEL:   high_in = csr_write_data;
            IDX_PIXEL_FORMAT: fmt_in  = csr_write_data[FMT_W-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff       <= '0;
         high_ff      <= BYTE_MAX;
         fmt_ff       <= FMT_PLANAR;
         div_start_ff <= 1'b0;
      end else begin
         low_ff       <= low_in;
         high_ff      <= high_in;
         fmt_ff       <= fmt_in;
         div_start_ff <= cfg_hit;
      end
   end

   // packed formats divide by high alone; planar (and code 3) by high - low
   assign divisor = (fmt_ff == FMT_YUYV || fmt_ff == FMT_UYVY) ?
                    {1'b0, high_ff} : ({1'b0, high_ff} - {1'b0, low_ff});

   lcs_gain_div u_gain_div (
      .clock   (clock),
      .reset   (reset),
      .start   (div_start_ff),
      .divisor (divisor),
      .status  (gain_status)
   );

   // ---- input skid and stage valids ----
   logic              adv;
   logic              accept;
   logic              skid_valid_ff, skid_valid_in;
   logic [BYTE_W-1:0] skid_first_ff, skid_second_ff;
   logic              skid_le_ff;
   logic              src_valid;
   logic [BYTE_W-1:0] src_first, src_second;
   logic              src_le;
   logic              v1_ff, v2_ff, v3_ff, v4_ff;
   logic              le1_ff, le2_ff, le3_ff, le4_ff;

   assign req_stall = skid_valid_ff || div_start_ff || gain_status.busy;
   assign accept    = req_valid && !req_stall;
   assign adv       = !v4_ff || !rsp_stall;

   assign src_valid  = skid_valid_ff || accept;
   assign src_first  = skid_valid_ff ? skid_first_ff  : req_in_first;
   assign src_second = skid_valid_ff ? skid_second_ff : req_in_second;
   assign src_le     = skid_valid_ff ? skid_le_ff     : req_line_end;

   // skid fills only when the chain is frozen and it is empty
   assign skid_valid_in = adv ? 1'b0 : (skid_valid_ff || accept);

   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
         v4_ff         <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
         if (adv) begin
            v1_ff <= src_valid;
            v2_ff <= v1_ff;
            v3_ff <= v2_ff;
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!adv && !skid_valid_ff && accept) begin
         skid_first_ff  <= req_in_first;
         skid_second_ff <= req_in_second;
         skid_le_ff     <= req_line_end;
      end
      if (adv) begin
         le1_ff <= src_le;
         le2_ff <= le1_ff;
         le3_ff <= le2_ff;
         le4_ff <= le3_ff;
      end
   end

   // ---- luma lanes ----
   lcs_lane_ctl_type lane_ctl;
   logic             byp_first, byp_second;

   assign lane_ctl.adv       = adv;
   assign lane_ctl.low_level = low_ff;
   assign lane_ctl.gain      = gain_status.gain;

   // chroma passes: first byte in UYVY, second byte in YUYV
   assign byp_first  = (fmt_ff == FMT_UYVY);
   assign byp_second = (fmt_ff == FMT_YUYV);

   lcs_luma_lane u_lane_first (
      .clock    (clock),
      .ctl      (lane_ctl),
      .in_byte  (src_first),
      .bypass   (byp_first),
      .out_byte (rsp_out_first)
   );

   lcs_luma_lane u_lane_second (
      .clock    (clock),
      .ctl      (lane_ctl),
      .in_byte  (src_second),
      .bypass   (byp_second),
      .out_byte (rsp_out_second)
   );

   assign rsp_valid        = v4_ff;
   assign rsp_line_end_out = le4_ff;

   // ---- checks ----
   `LCS_ASSERT_NEXT(a_cfg_blocks_input, clock, reset, cfg_hit, req_stall, "input open after config write")
   `LCS_ASSERT_SAME(a_div_blocks_input, clock, reset, gain_status.busy, req_stall, "input open during divide")
   `LCS_ASSERT_SAME(a_skid_blocks_input, clock, reset, skid_valid_ff, req_stall, "input open with skid full")
   `LCS_ASSERT_NEXT(a_stage3_holds, clock, reset, v3_ff && !adv, v3_ff, "stage 3 item lost while frozen")

endmodule
